[design/krst_pkg.sv]
// Shared types and constants for the keyed record slot table.
// Has no dependencies. The top level uses it; the cell does not.
package krst_pkg;

    // Default table size and content width.
    localparam int SLOTS_DEF        = 128;
    localparam int CONTENT_BITS_DEF = 64;

    // Configuration register indexes and reset values.
    localparam logic [1:0] CFG_SLOTS_IN_USE = 2'd0;
    localparam logic [1:0] CFG_SORTED_MODE  = 2'd1;
    localparam logic [7:0] SLOTS_IN_USE_RST = 8'd128;

    // Command codes. Code 7 has no meaning and is answered at once without a ring turn.
    typedef enum logic [2:0] {
        FN_INSERT  = 3'd0,
        FN_SEARCH  = 3'd1,
        FN_EDIT    = 3'd2,
        FN_DELETE  = 3'd3,
        FN_SORT    = 3'd4,
        FN_COMPACT = 3'd5,
        FN_CLEAR   = 3'd6
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    // Command beat.
    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] record_key;
        logic [63:0]        content_word;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  slot_index;
        logic [63:0] found_content;
    } t_out_beat;

endpackage

[design/krst_cell.sv]
// One slot of the rotating slot ring: occupied mark, key and content.
// Depends on nothing; instantiated in a chain by the top level.
module krst_cell #(
    parameter int CONTENT_BITS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_shift,
    input  logic                    i_occ,
    input  logic [31:0]             i_key,
    input  logic [CONTENT_BITS-1:0] i_content,
    output logic                    o_occ,
    output logic [31:0]             o_key,
    output logic [CONTENT_BITS-1:0] o_content
);

    logic                    r_occ;
    logic [31:0]             r_key;
    logic [CONTENT_BITS-1:0] r_content;

    // The occupied mark is cleared at reset, so every slot starts empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_shift) begin
            r_occ <= i_occ;
        end
    end

    // Key and content move with the ring and need no reset.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key     <= i_key;
            r_content <= i_content;
        end
    end

    assign o_occ     = r_occ;
    assign o_key     = r_key;
    assign o_content = r_content;

endmodule

[design/keyed_record_slot_table_unit.sv]
// Top level of the keyed record slot table: ring of slot cells and command sequencer.
// Depends on krst_pkg and krst_cell.
//
//  channel  | valid       | flow control  | payload
//  ---------+-------------+---------------+---------------------------------
//  command  | i_in_valid  | o_in_stall    | i_in_data  (t_in_beat)
//  result   | o_out_valid | i_out_stall   | o_out_data (t_out_beat)
//  config   | i_cfg_valid | o_cfg_ready   | i_cfg_index, i_cfg_data
//
// The slots and a hold register form a ring that turns past one compare point.
// Insert, search, edit, delete and clear take one turn; sort takes n+1 turns and
// compact up to n+1 turns (n the usable slot count). The result is valid in the cycle
// after the last turn, and the next beat is taken in the idle cycle after the result
// beat has gone. Unused codes and a disabled sort skip the ring.
// Reset is synchronous and empties every slot at once. A stalled result holds.
module keyed_record_slot_table_unit #(
    parameter int SLOTS        = krst_pkg::SLOTS_DEF,
    parameter int CONTENT_BITS = krst_pkg::CONTENT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  krst_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output krst_pkg::t_out_beat o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    import krst_pkg::*;

    localparam int TW = $clog2(SLOTS + 1);
    localparam int EW = (TW > 8) ? TW : 8;
    localparam int CB = CONTENT_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // Ring of cells.
    logic          c_occ  [SLOTS];
    logic [31:0]   c_key  [SLOTS];
    logic [CB-1:0] c_cont [SLOTS];
    logic          shift;
    logic          w_occ;
    logic [31:0]   w_key;
    logic [CB-1:0] w_cont;

    genvar k;
    generate
        for (k = 0; k < SLOTS; k++) begin : g_ring
            if (k == SLOTS - 1) begin : g_tail
                krst_cell #(.CONTENT_BITS(CB)) u_cell (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(shift),
                    .i_occ(w_occ), .i_key(w_key), .i_content(w_cont),
                    .o_occ(c_occ[k]), .o_key(c_key[k]), .o_content(c_cont[k])
                );
            end else begin : g_body
                krst_cell #(.CONTENT_BITS(CB)) u_cell (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(shift),
                    .i_occ(c_occ[k+1]), .i_key(c_key[k+1]), .i_content(c_cont[k+1]),
                    .o_occ(c_occ[k]), .o_key(c_key[k]), .o_content(c_cont[k])
                );
            end
        end
    endgenerate

    // Sequencer registers.
    t_state        r_state, n_state;
    logic [7:0]    r_cfg_slots, n_cfg_slots;
    logic          r_sorted, n_sorted;
    t_func         r_func, n_func;
    logic [31:0]   r_key, n_key;
    logic [CB-1:0] r_word, n_word;
    logic [TW-1:0] r_t, n_t;
    logic [TW-1:0] r_r, n_r;
    logic          r_hit, n_hit;
    logic [TW-1:0] r_idx, n_idx;
    logic [CB-1:0] r_fcont, n_fcont;
    logic          r_h_occ, n_h_occ;
    logic [31:0]   r_h_key, n_h_key;
    logic [CB-1:0] r_h_cont, n_h_cont;
    logic          r_sv, n_sv;
    logic [31:0]   r_s_key, n_s_key;
    logic [CB-1:0] r_s_cont, n_s_cont;
    logic          r_swapped, n_swapped;
    t_out_beat     r_res, n_res;

    logic [EW-1:0]   cfg_ext;
    logic [TW-1:0]   n_act;
    logic [TW-1:0]   q;
    logic [TW+6:0]   idx_ext;
    logic            in_range;
    logic            finish;

    // Usable slot count, saturated to the table size.
    assign cfg_ext = EW'(r_cfg_slots);
    assign n_act   = (cfg_ext > EW'(SLOTS)) ? TW'(SLOTS) : TW'(cfg_ext);

    // The slot finalised this cycle is the one held back in the delay register.
    assign q        = r_t - 1'b1;
    assign in_range = (q < n_act);

    always_comb begin
        n_state     = r_state;
        n_cfg_slots = r_cfg_slots;
        n_sorted    = r_sorted;
        n_func      = r_func;
        n_key       = r_key;
        n_word      = r_word;
        n_t         = r_t;
        n_r         = r_r;
        n_hit       = r_hit;
        n_idx       = r_idx;
        n_fcont     = r_fcont;
        n_h_occ     = r_h_occ;
        n_h_key     = r_h_key;
        n_h_cont    = r_h_cont;
        n_sv        = r_sv;
        n_s_key     = r_s_key;
        n_s_cont    = r_s_cont;
        n_swapped   = r_swapped;
        n_res       = r_res;
        shift       = 1'b0;
        w_occ       = r_h_occ;
        w_key       = r_h_key;
        w_cont      = r_h_cont;
        finish      = 1'b0;
        idx_ext     = '0;

        // Configuration writes are always taken.
        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SLOTS_IN_USE) begin
                n_cfg_slots = i_cfg_data;
            end else if (i_cfg_index == CFG_SORTED_MODE) begin
                n_sorted = i_cfg_data[0];
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func    = t_func'(i_in_data.func);
                    n_key     = i_in_data.record_key;
                    n_word    = CB'(i_in_data.content_word);
                    n_t       = '0;
                    n_r       = '0;
                    n_hit     = 1'b0;
                    n_sv      = 1'b0;
                    n_swapped = 1'b0;
                    n_res     = '0;
                    n_state   = S_RUN;
                    // Unused codes and a disabled sort answer at once.
                    if (i_in_data.func == 3'(7) ||
                        (t_func'(i_in_data.func) == FN_SORT && !r_sorted)) begin
                        n_state = S_DONE;
                    end
                end
            end

            S_RUN: begin
                shift    = 1'b1;
                n_t      = r_t + 1'b1;
                n_h_occ  = c_occ[0];
                n_h_key  = c_key[0];
                n_h_cont = c_cont[0];
                if (r_t != '0) begin
                    case (r_func)
                        FN_INSERT: begin
                            if (in_range && !r_h_occ && !r_hit) begin
                                w_occ  = 1'b1;
                                w_key  = r_key;
                                w_cont = r_word;
                                n_hit  = 1'b1;
                                n_idx  = q;
                            end
                        end
                        FN_SEARCH, FN_EDIT, FN_DELETE: begin
                            if (in_range && r_h_occ && r_h_key == r_key && !r_hit) begin
                                n_hit   = 1'b1;
                                n_idx   = q;
                                n_fcont = r_h_cont;
                                if (r_func == FN_EDIT) begin
                                    w_cont = r_word;
                                end else if (r_func == FN_DELETE) begin
                                    w_occ = 1'b0;
                                end
                            end
                        end
                        FN_CLEAR: begin
                            w_occ = 1'b0;
                        end
                        FN_SORT: begin
                            // Write back the minimum of the previous pass, pick up the
                            // pivot of this pass, then swap against smaller keys.
                            if (r_r != '0 && q == r_r - 1'b1) begin
                                if (r_sv) begin
                                    w_key  = r_s_key;
                                    w_cont = r_s_cont;
                                end
                            end else if (r_r < n_act && q == r_r) begin
                                n_sv     = r_h_occ;
                                n_s_key  = r_h_key;
                                n_s_cont = r_h_cont;
                            end else if (r_r < n_act && q > r_r && in_range && r_sv &&
                                         r_h_occ &&
                                         $signed(r_s_key) > $signed(r_h_key)) begin
                                w_key    = r_s_key;
                                w_cont   = r_s_cont;
                                n_s_key  = r_h_key;
                                n_s_cont = r_h_cont;
                            end
                        end
                        FN_COMPACT: begin
                            // A hole followed by a record swaps, so holes bubble up.
                            if (!r_h_occ && r_t < n_act && c_occ[0]) begin
                                w_occ     = 1'b1;
                                w_key     = c_key[0];
                                w_cont    = c_cont[0];
                                n_h_occ   = 1'b0;
                                n_swapped = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                // End of one turn of the ring.
                if (r_t == TW'(SLOTS)) begin
                    n_t = '0;
                    case (r_func)
                        FN_SORT: begin
                            if (r_r == n_act) begin
                                finish = 1'b1;
                            end else begin
                                n_r = r_r + 1'b1;
                            end
                        end
                        FN_COMPACT: begin
                            if (n_swapped) begin
                                n_swapped = 1'b0;
                            end else begin
                                finish = 1'b1;
                            end
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end

                if (finish) begin
                    n_state = S_DONE;
                    idx_ext = {7'b0, n_idx};
                    n_res   = '0;
                    case (r_func)
                        FN_INSERT: begin
                            n_res.status = n_hit ? ST_OK : ST_FULL;
                            n_res.slot_index = n_hit ? idx_ext[6:0] : 7'd0;
                        end
                        FN_SEARCH: begin
                            n_res.status = n_hit ? ST_OK : ST_NOTFOUND;
                            n_res.slot_index = n_hit ? idx_ext[6:0] : 7'd0;
                            n_res.found_content = n_hit ? 64'(n_fcont) : 64'd0;
                        end
                        FN_EDIT, FN_DELETE: begin
                            n_res.status = n_hit ? ST_OK : ST_NOTFOUND;
                            n_res.slot_index = n_hit ? idx_ext[6:0] : 7'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_slots <= SLOTS_IN_USE_RST;
            r_sorted    <= 1'b0;
            r_t         <= '0;
            r_r         <= '0;
            r_hit       <= 1'b0;
            r_sv        <= 1'b0;
            r_swapped   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg_slots <= n_cfg_slots;
            r_sorted    <= n_sorted;
            r_t         <= n_t;
            r_r         <= n_r;
            r_hit       <= n_hit;
            r_sv        <= n_sv;
            r_swapped   <= n_swapped;
        end
        r_func   <= n_func;
        r_key    <= n_key;
        r_word   <= n_word;
        r_idx    <= n_idx;
        r_fcont  <= n_fcont;
        r_h_occ  <= n_h_occ;
        r_h_key  <= n_h_key;
        r_h_cont <= n_h_cont;
        r_s_key  <= n_s_key;
        r_s_cont <= n_s_cont;
        r_res    <= n_res;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_out_data  = r_res;
    assign o_cfg_ready = 1'b1;

endmodule
